/* hdl/utf8_stream_decoder_macros.svh */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// The enclosing scope must provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication
`define UTF8SD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/utf8sd_pkg.sv */
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	// Input transaction payload
	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	// Output transaction payload
	typedef struct packed {
		logic [20:0] code_point;
		logic        bad_sequence;
	} out_item_t;

	// Decoder states, one-hot
	typedef enum logic [7:0] {
		ST_START    = 8'b0000_0001,
		ST_NEED1    = 8'b0000_0010,
		ST_NEED2    = 8'b0000_0100,
		ST_AFTER_E0 = 8'b0000_1000,
		ST_AFTER_ED = 8'b0001_0000,
		ST_NEED3    = 8'b0010_0000,
		ST_AFTER_F0 = 8'b0100_0000,
		ST_AFTER_F4 = 8'b1000_0000
	} dfa_state_t;

	// Input mode codes
	localparam logic MODE_DATA    = 1'b0;
	localparam logic MODE_ABANDON = 1'b1;

	// Register index, taken from paddr[2]
	localparam logic REG_C1_BLOCK = 1'b0;

	localparam int unsigned ADDR_W = 3;

	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	// Result of one decoder step
	typedef struct packed {
		dfa_state_t  next_state;
		logic [20:0] next_partial;
		logic        emit;
		out_item_t   result;
	} step_out_t;

endpackage

/* hdl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Validating UTF-8 decoder: one byte in, at most one code point out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one byte (or an abandon request when
//   mode is 1) per transaction. out_valid/out_ready/out_data carry one
//   decoded code point, or U+FFFD with bad_sequence set on an error.
//   Bytes that leave a sequence incomplete, and abandon requests, give
//   no output transaction.
//   Path: an accepted byte is held in the input register, and its result
//   is loaded into the result register when stage 1 advances.
//   Throughput: one byte per cycle while the output is not stalled; the
//   decoder state is updated in the same step that fills the result register.
//   Stall: while the result register is full and out_ready is low, the
//   input register holds one more byte and then in_ready drops.
//   Reset: arst_n clears both valid flags, returns the decoder to its
//   start state and clears the C1 blocking bit, which the APB port writes
//   at address 0; write it only while the decoder is idle.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  utf8sd_pkg::in_item_t          in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output utf8sd_pkg::out_item_t         out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [utf8sd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic                   c1_block_en;
	logic                   valid_s1;
	utf8sd_pkg::in_item_t   item_s1;
	utf8sd_pkg::dfa_state_t state_q;
	logic [20:0]            partial_q;
	logic                   out_valid_q;
	utf8sd_pkg::out_item_t  out_data_q;
	utf8sd_pkg::step_out_t  step;
	logic                   advance;

	utf8sd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.c1_block_en (c1_block_en)
	);

	utf8sd_step u_step (
		.state       (state_q),
		.partial     (partial_q),
		.item        (item_s1),
		.c1_block_en (c1_block_en),
		.step        (step)
	);

	// Advance stage 1 when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= utf8sd_pkg::ST_START;
			partial_q <= 21'd0;
		end else if (advance) begin
			state_q   <= step.next_state;
			partial_q <= step.next_partial;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			out_data_q <= step.result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* hdl/utf8sd_regs.sv */
// ----------------------------------------------------------------------------
// utf8sd_regs
// APB register file holding the C1 blocking mode bit.
// ----------------------------------------------------------------------------
module utf8sd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [utf8sd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic                          c1_block_en
);

	logic c1_block_en_q;
	logic wr_hit;

	// Decode a completed write to the mode register
	assign wr_hit = psel && penable && pwrite && (paddr[2] == utf8sd_pkg::REG_C1_BLOCK);

	// Hold the mode bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_block_en_q <= 1'b0;
		end else if (wr_hit) begin
			c1_block_en_q <= pwdata[0];
		end
	end

	// Read back; addresses beyond the register read as zero
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == utf8sd_pkg::REG_C1_BLOCK) begin
			prdata = {31'd0, c1_block_en_q};
		end
	end

	assign pready      = 1'b1;
	assign c1_block_en = c1_block_en_q;

endmodule

/* hdl/utf8sd_step.sv */
// ----------------------------------------------------------------------------
// utf8sd_step
// One step of the validating UTF-8 state machine: range check, payload
// accumulation and result generation for a single input transaction.
// ----------------------------------------------------------------------------
module utf8sd_step (
	input  utf8sd_pkg::dfa_state_t state,
	input  logic [20:0]            partial,
	input  utf8sd_pkg::in_item_t   item,
	input  logic                   c1_block_en,
	output utf8sd_pkg::step_out_t  step
);

	logic [7:0]             b;
	logic [7:0]             lo;
	logic [7:0]             hi;
	logic                   cont;
	utf8sd_pkg::dfa_state_t cont_next;
	logic [20:0]            shifted;

	assign b       = item.data_byte;
	assign shifted = {partial[14:0], b[5:0]};

	// Continuation byte window and follow-on state
	always_comb begin
		cont      = 1'b1;
		lo        = 8'h80;
		hi        = 8'hBF;
		cont_next = utf8sd_pkg::ST_START;
		unique case (state)
			utf8sd_pkg::ST_NEED1: begin
				cont_next = utf8sd_pkg::ST_START;
			end
			utf8sd_pkg::ST_NEED2: begin
				cont_next = utf8sd_pkg::ST_NEED1;
			end
			utf8sd_pkg::ST_AFTER_E0: begin
				cont_next = utf8sd_pkg::ST_NEED1;
				lo        = 8'hA0;
			end
			utf8sd_pkg::ST_AFTER_ED: begin
				cont_next = utf8sd_pkg::ST_NEED1;
				hi        = 8'h9F;
			end
			utf8sd_pkg::ST_NEED3: begin
				cont_next = utf8sd_pkg::ST_NEED2;
			end
			utf8sd_pkg::ST_AFTER_F0: begin
				cont_next = utf8sd_pkg::ST_NEED2;
				lo        = 8'h90;
			end
			utf8sd_pkg::ST_AFTER_F4: begin
				cont_next = utf8sd_pkg::ST_NEED2;
				hi        = 8'h8F;
			end
			default: begin
				cont = 1'b0;
			end
		endcase
	end

	// Next state, payload and result
	always_comb begin
		step.next_state          = utf8sd_pkg::ST_START;
		step.next_partial        = 21'd0;
		step.emit                = 1'b0;
		step.result.code_point   = utf8sd_pkg::REPLACEMENT_CP;
		step.result.bad_sequence = 1'b1;

		if (item.mode == utf8sd_pkg::MODE_ABANDON) begin
			// Drop any partial sequence silently
			step.emit = 1'b0;
		end else if (cont) begin
			if (b < lo || b > hi) begin
				step.emit = 1'b1;
			end else if (cont_next == utf8sd_pkg::ST_START) begin
				step.emit                = 1'b1;
				step.result.code_point   = shifted;
				step.result.bad_sequence = 1'b0;
			end else begin
				step.next_state   = cont_next;
				step.next_partial = shifted;
			end
		end else if (c1_block_en && b >= 8'h80 && b <= 8'h9F) begin
			// C1 control at the start state
			step.emit = 1'b1;
		end else if (b < 8'h80) begin
			step.emit                = 1'b1;
			step.result.code_point   = {13'd0, b};
			step.result.bad_sequence = 1'b0;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			step.next_state   = utf8sd_pkg::ST_NEED1;
			step.next_partial = {16'd0, b[4:0]};
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			step.next_partial = {17'd0, b[3:0]};
			if (b == 8'hE0) begin
				step.next_state = utf8sd_pkg::ST_AFTER_E0;
			end else if (b == 8'hED) begin
				step.next_state = utf8sd_pkg::ST_AFTER_ED;
			end else begin
				step.next_state = utf8sd_pkg::ST_NEED2;
			end
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			step.next_partial = {18'd0, b[2:0]};
			if (b == 8'hF0) begin
				step.next_state = utf8sd_pkg::ST_AFTER_F0;
			end else if (b == 8'hF4) begin
				step.next_state = utf8sd_pkg::ST_AFTER_F4;
			end else begin
				step.next_state = utf8sd_pkg::ST_NEED3;
			end
		end else begin
			// Stray continuation, 0xC0, 0xC1 or 0xF5-0xFF
			step.emit = 1'b1;
		end
	end

endmodule

/* hdl/utf8sd_checker.sv */
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module utf8sd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input utf8sd_pkg::out_item_t out_data
);

	// A stalled result holds
	`UTF8SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// Errors always carry the replacement character
	`UTF8SD_ASSERT_NOW(a_err_cp, out_valid && out_data.bad_sequence, out_data.code_point == utf8sd_pkg::REPLACEMENT_CP, "error result is not U+FFFD")

	// Good results are scalar values: no surrogate, nothing above U+10FFFF
	`UTF8SD_ASSERT_NOW(a_scalar, out_valid && !out_data.bad_sequence, out_data.code_point <= 21'h10FFFF && out_data.code_point[20:11] != 10'h01B, "decoded value is not a scalar value")

	// A fresh result follows an input transaction through the input and result registers
	`UTF8SD_ASSERT_NOW(a_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a preceding input transaction")

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* bench/utf8_stream_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the UTF-8 stream decoder. A queue of bytes and
// abandon requests, directed first and then mostly well-formed random text
// with broken sequences and noise mixed in, feeds a valid/ready driver. A
// local decoder model predicts each code point, and a monitor compares
// every output transaction against it. The run steps through four idle
// and stall profiles and toggles the C1 blocking bit through the APB port
// between them.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 410;
	localparam int unsigned SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	utf8sd_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	utf8sd_pkg::out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [utf8sd_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Decoder model state and its copy of the register
	utf8sd_pkg::dfa_state_t dec_state = utf8sd_pkg::ST_START;
	logic [20:0] dec_partial = '0;
	logic c1_reject = 1'b0;

	utf8sd_pkg::in_item_t pending_items[$];
	utf8sd_pkg::out_item_t expected_points[$];
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;

	utf8_stream_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the model by one transaction; return 1 when it yields a code point
	function automatic logic decode_step(input utf8sd_pkg::in_item_t item,
		output utf8sd_pkg::out_item_t res);
		logic [7:0] b;
		logic [7:0] lo;
		logic [7:0] hi;
		utf8sd_pkg::dfa_state_t nxt;
		logic in_seq;
		logic emit;
		logic bad;
		b = item.data_byte;
		lo = 8'h80;
		hi = 8'hBF;
		nxt = utf8sd_pkg::ST_START;
		in_seq = 1'b1;
		emit = 1'b0;
		bad = 1'b0;
		res = '0;
		if (item.mode == utf8sd_pkg::MODE_ABANDON) begin
			dec_state = utf8sd_pkg::ST_START;
			dec_partial = '0;
		end else begin
			// Pick the allowed continuation range for the current state
			case (dec_state)
				utf8sd_pkg::ST_NEED1: nxt = utf8sd_pkg::ST_START;
				utf8sd_pkg::ST_NEED2: nxt = utf8sd_pkg::ST_NEED1;
				utf8sd_pkg::ST_AFTER_E0: begin
					nxt = utf8sd_pkg::ST_NEED1;
					lo = 8'hA0;
				end
				utf8sd_pkg::ST_AFTER_ED: begin
					nxt = utf8sd_pkg::ST_NEED1;
					hi = 8'h9F;
				end
				utf8sd_pkg::ST_NEED3: nxt = utf8sd_pkg::ST_NEED2;
				utf8sd_pkg::ST_AFTER_F0: begin
					nxt = utf8sd_pkg::ST_NEED2;
					lo = 8'h90;
				end
				utf8sd_pkg::ST_AFTER_F4: begin
					nxt = utf8sd_pkg::ST_NEED2;
					hi = 8'h8F;
				end
				default: in_seq = 1'b0;
			endcase
			if (!in_seq) begin
				// Classify a byte at the start state
				dec_state = utf8sd_pkg::ST_START;
				dec_partial = '0;
				if (c1_reject && b >= 8'h80 && b <= 8'h9F) begin
					bad = 1'b1;
				end else if (b < 8'h80) begin
					emit = 1'b1;
					res.code_point = {13'd0, b};
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					dec_partial = {16'd0, b[4:0]};
					dec_state = utf8sd_pkg::ST_NEED1;
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					dec_partial = {17'd0, b[3:0]};
					dec_state = (b == 8'hE0) ? utf8sd_pkg::ST_AFTER_E0 :
						(b == 8'hED) ? utf8sd_pkg::ST_AFTER_ED : utf8sd_pkg::ST_NEED2;
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					dec_partial = {18'd0, b[2:0]};
					dec_state = (b == 8'hF0) ? utf8sd_pkg::ST_AFTER_F0 :
						(b == 8'hF4) ? utf8sd_pkg::ST_AFTER_F4 : utf8sd_pkg::ST_NEED3;
				end else begin
					bad = 1'b1;
				end
			end else if (b < lo || b > hi) begin
				bad = 1'b1;
			end else begin
				// Shift in six payload bits
				dec_partial = {dec_partial[14:0], b[5:0]};
				dec_state = nxt;
				if (nxt == utf8sd_pkg::ST_START) begin
					emit = 1'b1;
					res.code_point = dec_partial;
					dec_partial = '0;
				end
			end
			if (bad) begin
				dec_state = utf8sd_pkg::ST_START;
				dec_partial = '0;
				emit = 1'b1;
				res.code_point = utf8sd_pkg::REPLACEMENT_CP;
				res.bad_sequence = 1'b1;
			end
		end
		return emit;
	endfunction

	// Driver: predict on each accepted transaction, then present the next one
	always @(posedge clk) begin : drive_inputs
		utf8sd_pkg::out_item_t pt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				items_taken <= items_taken + 1;
				if (decode_step(in_data, pt)) expected_points.push_back(pt);
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest prediction
	always @(posedge clk) begin : check_outputs
		utf8sd_pkg::out_item_t want;
		logic miss;
		miss = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					miss = 1'b1;
					$display("%0t: unexpected result: expected none, actual cp=%h bad=%b",
						$time, out_data.code_point, out_data.bad_sequence);
				end else begin
					want = expected_points.pop_front();
					if (out_data.code_point !== want.code_point) begin
						miss = 1'b1;
						$display("%0t: code_point: expected %h, actual %h",
							$time, want.code_point, out_data.code_point);
					end
					if (out_data.bad_sequence !== want.bad_sequence) begin
						miss = 1'b1;
						$display("%0t: bad_sequence: expected %b, actual %b",
							$time, want.bad_sequence, out_data.bad_sequence);
					end
				end
			end
			// Count at most one mismatch per transaction
			if (miss) mismatches <= mismatches + 1;
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("utf8_stream_decoder: mismatch");
			$finish;
		end
	end

	task automatic queue_item(input logic mode, input logic [7:0] b);
		utf8sd_pkg::in_item_t it;
		it.mode = mode;
		it.data_byte = b;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_bytes(input logic [7:0] seq[$]);
		foreach (seq[i]) queue_item(utf8sd_pkg::MODE_DATA, seq[i]);
	endtask

	// Encode a scalar value as UTF-8
	function automatic void encode_point(input logic [20:0] cp, output logic [7:0] seq[$]);
		seq = {};
		if (cp < 21'h80) begin
			seq.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			seq.push_back({3'b110, cp[10:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			seq.push_back({4'b1110, cp[15:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else begin
			seq.push_back({5'b11110, cp[20:18]});
			seq.push_back({2'b10, cp[17:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// Draw a scalar value, spread evenly over the four encoded lengths
	function automatic logic [20:0] random_point();
		logic [20:0] cp;
		case ($urandom_range(3))
			0: cp = 21'($urandom_range(8'h7F));
			1: cp = 21'($urandom_range(11'h7FF, 8'h80));
			2: begin
				cp = 21'($urandom_range(16'hFFFF, 12'h800));
				// move surrogates out of the way
				if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;
			end
			default: cp = 21'($urandom_range(21'h10FFFF, 17'h10000));
		endcase
		return cp;
	endfunction

	// Queue one random chunk: mostly valid text, else broken sequences and noise
	task automatic queue_random_chunk();
		logic [7:0] seq[$];
		logic [7:0] cont;
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		cont = {2'b10, 6'($urandom_range(63))};
		if (r < 62) begin
			encode_point(random_point(), seq);
			queue_bytes(seq);
		end else if (r < 80) begin
			// corrupt a multi-byte sequence
			do encode_point(random_point(), seq); while (seq.size() < 2);
			case ($urandom_range(3))
				0: begin
					k = $urandom_range(seq.size() - 1, 1);
					while (seq.size() > k) void'(seq.pop_back());
				end
				1: seq[$urandom_range(seq.size() - 1, 1)] = 8'($urandom_range(255));
				2: seq[$urandom_range(seq.size() - 1, 1)] = 8'($urandom_range(8'hFF, 8'hC0));
				default: begin
					k = $urandom_range(seq.size() - 1, 1);
					for (int unsigned i = 0; i < seq.size(); i++) begin
						if (i == k) queue_item(utf8sd_pkg::MODE_ABANDON, 8'($urandom_range(255)));
						queue_item(utf8sd_pkg::MODE_DATA, seq[i]);
					end
					seq = {};
				end
			endcase
			queue_bytes(seq);
		end else if (r < 88) begin
			// overlong, surrogate and out-of-range forms
			case ($urandom_range(4))
				0: seq = '{8'($urandom_range(8'hC1, 8'hC0)), cont};
				1: seq = '{8'hE0, 8'($urandom_range(8'h9F, 8'h80)), cont};
				2: seq = '{8'hED, 8'($urandom_range(8'hBF, 8'hA0)), cont};
				3: seq = '{8'hF0, 8'($urandom_range(8'h8F, 8'h80)), cont, cont};
				default: seq = '{8'hF4, 8'($urandom_range(8'hBF, 8'h90)), cont, cont};
			endcase
			queue_bytes(seq);
		end else if (r < 96) begin
			queue_item(utf8sd_pkg::MODE_DATA, 8'($urandom_range(255)));
		end else begin
			queue_item(utf8sd_pkg::MODE_ABANDON, 8'($urandom_range(255)));
		end
	endtask

	// Hold until every queued transaction is in and every result is out
	task automatic wait_drained();
		while (items_taken != items_queued || expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_c1_block(input logic val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= utf8sd_pkg::ADDR_W'({utf8sd_pkg::REG_C1_BLOCK, 2'b00});
		pwdata <= {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		c1_reject = val;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: boundary code points of each length, boundary errors, abandon mid-sequence
		queue_bytes('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF});
		queue_bytes('{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF});
		queue_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC0, 8'hFF, 8'h80});
		queue_bytes('{8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF1, 8'h80});
		queue_item(utf8sd_pkg::MODE_ABANDON, 8'hFF);
		queue_bytes('{8'hE1, 8'hC3});

		for (int phase = 0; phase < 4; phase++) begin
			if (phase > 0) write_c1_block(phase[0]);
			case (phase)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 45;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 45;
				end
				default: begin
					send_gap_pct = 21;
					recv_stall_pct = 21;
				end
			endcase
			while (pending_items.size() < PHASE_ITEMS) queue_random_chunk();
			wait_drained();
		end

		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("utf8_stream_decoder: match");
		end else begin
			$display("utf8_stream_decoder: mismatch");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/utf8sd_pkg.sv
hdl/utf8sd_regs.sv
hdl/utf8sd_step.sv
hdl/utf8_stream_decoder.sv
hdl/utf8sd_checker.sv
bench/utf8_stream_decoder_tb.sv
